// ----- src/idta_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the microcode program of the interrupt device table allocator.
// No dependencies; idta_seq, idta_dp and the top level import this package.
package idta_pkg;

  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned ALIGN_BYTES_DEF = 256;

  // 65535 vectors round to 2^16, times 16 bytes gives 2^20; alignment never passes it
  localparam int unsigned NEED_W      = 21;
  localparam int unsigned RECIP_W     = 31;
  localparam int unsigned RECIP_SHIFT = 34;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] ID_BITS_RST    = 5'd16;
  localparam logic [CFG_W-1:0] ENTRY_BYTES_RST = 5'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ID_BITS = 1'b0,
    CFG_ENTRY_BYTES    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_FITS       = 3'd1,
    ST_RANGE      = 3'd2,
    ST_SMALL      = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_ARENA_FULL = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] device_id;
    logic [15:0] vector_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] space_offset;
    logic [12:0] space_bytes;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] device_id_bits;
    logic [CFG_W-1:0] entry_bytes;
  } cfg_t;

  // microcode
  typedef enum logic [2:0] {
    OP_IDLE, OP_POW, OP_RECIP, OP_ALIGN, OP_SCAN, OP_ROOM, OP_GRANT, OP_RESULT
  } op_e;

  typedef enum logic [1:0] {
    C_NEVER, C_RANGE, C_HIT, C_NOFIT
  } cond_e;

  typedef enum logic [1:0] {
    W_NONE, W_NOACC, W_SCAN, W_OUTFULL
  } wait_e;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_RESULT = 3'd7;

  typedef struct packed {
    op_e   op;
    cond_e jmp;
    upc_t  target;
    wait_e wt;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic range_bad;
    logic hit;
    logic nofit;
    logic scan_last;
    logic out_full;
  } dp_flags_t;

  // jump has priority over wait, wait over step+1; the last step wraps to idle
  function automatic ucode_t ucode_rom(upc_t upc);
    ucode_t w;
    unique case (upc)
      3'd0: w = '{op: OP_IDLE,   jmp: C_NEVER, target: 3'd0,       wt: W_NOACC};
      3'd1: w = '{op: OP_POW,    jmp: C_NEVER, target: 3'd0,       wt: W_NONE};
      3'd2: w = '{op: OP_RECIP,  jmp: C_NEVER, target: 3'd0,       wt: W_NONE};
      3'd3: w = '{op: OP_ALIGN,  jmp: C_RANGE, target: UPC_RESULT, wt: W_NONE};
      3'd4: w = '{op: OP_SCAN,   jmp: C_HIT,   target: UPC_RESULT, wt: W_SCAN};
      3'd5: w = '{op: OP_ROOM,   jmp: C_NOFIT, target: UPC_RESULT, wt: W_NONE};
      3'd6: w = '{op: OP_GRANT,  jmp: C_NEVER, target: 3'd0,       wt: W_NONE};
      3'd7: w = '{op: OP_RESULT, jmp: C_NEVER, target: 3'd0,       wt: W_OUTFULL};
    endcase
    return w;
  endfunction

endpackage

// ----- src/idta_chan_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of type T.
// No dependencies; payload types come from idta_pkg at instantiation.
interface idta_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/idta_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/idta_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program ROM and conditional jump/wait logic.
// Depends on idta_pkg.
module idta_seq
  import idta_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_flags_t flags_i,
  output op_e       op_o
);

  upc_t   upc_q, upc_d;
  ucode_t cw;
  logic   jump, stay;

  assign cw = ucode_rom(upc_q);

  always_comb begin
    unique case (cw.jmp)
      C_NEVER: jump = 1'b0;
      C_RANGE: jump = flags_i.range_bad;
      C_HIT:   jump = flags_i.hit;
      C_NOFIT: jump = flags_i.nofit;
    endcase
  end

  always_comb begin
    unique case (cw.wt)
      W_NONE:    stay = 1'b0;
      W_NOACC:   stay = !flags_i.accept;
      W_SCAN:    stay = !flags_i.scan_last;
      W_OUTFULL: stay = flags_i.out_full;
    endcase
  end

  always_comb begin
    priority if (jump) begin
      upc_d = cw.target;
    end else if (stay) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign op_o = cw.op;

endmodule

// ----- src/idta_dp.sv -----
`timescale 1ns / 1ps
// Datapath: sizing arithmetic, slot table (valid flops plus RAM), arena counter, result register.
// Depends on idta_pkg, idta_chan_if and idta_ram.
module idta_dp
  import idta_pkg::*;
#(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  op_e         op_i,
  output dp_flags_t   flags_o,
  idta_chan_if.sink   req,
  idta_chan_if.source rsp
);

  localparam int unsigned SlotW      = ($clog2(SLOTS) > 0) ? $clog2(SLOTS) : 1;
  localparam int unsigned ArenaBytes = SLOTS * ALIGN_BYTES;
  localparam int unsigned UsedW      = $clog2(ArenaBytes + 1);
  localparam int unsigned AlignW     = $clog2(ALIGN_BYTES + 1);
  localparam int unsigned ProdW      = NEED_W + RECIP_W;
  localparam int unsigned QW         = ProdW - RECIP_SHIFT;
  localparam int unsigned RamW       = 16 + UsedW;
  localparam longint unsigned Recip =
    ((64'd1 << RECIP_SHIFT) + longint'(ALIGN_BYTES) - 64'd1) / longint'(ALIGN_BYTES);
  localparam logic [RECIP_W-1:0] RecipV  = RECIP_W'(Recip);
  localparam logic [AlignW-1:0]  AlignV  = AlignW'(ALIGN_BYTES);
  localparam logic [NEED_W-1:0]  AlignM1 = NEED_W'(ALIGN_BYTES - 1);
  localparam logic [NEED_W:0]    ArenaV  = (NEED_W + 1)'(ArenaBytes);

  // control state
  logic [SLOTS-1:0]  slot_vld_q, slot_vld_d;
  logic [UsedW-1:0]  used_q, used_d;
  logic              out_vld_q, out_vld_d;
  // payload
  logic [15:0]       id_q, id_d;
  logic [15:0]       cnt_q, cnt_d;
  logic [NEED_W-1:0] raw_q, raw_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic              free_found_q, free_found_d;
  logic [SlotW-1:0]  free_idx_q, free_idx_d;
  status_e           status_q, status_d;
  logic [UsedW-1:0]  grant_off_q, grant_off_d;
  logic [UsedW-1:0]  grant_bytes_q, grant_bytes_d;
  rsp_t              out_q, out_d;

  logic              accept, out_full, hit, fits, overflow, last;
  logic              ram_we;
  logic [RamW-1:0]   ram_rdata;
  logic [15:0]       rd_dev;
  logic [UsedW-1:0]  rd_bytes;
  logic [15:0]       vec, smear;
  logic [16:0]       pow;
  logic [CFG_W-1:0]  eb;
  logic [21:0]       raw_full;
  logic [QW-1:0]     quot;
  logic [QW+AlignW-1:0] need_full;
  logic [NEED_W:0]   sum;
  logic [NEED_W:0]   off_w, bytes_w;

  idta_ram #(.WIDTH(RamW), .DEPTH(SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i({id_q, need_q[UsedW-1:0]}),
    .raddr_i(idx_d),
    .rdata_o(ram_rdata)
  );

  assign rd_dev   = ram_rdata[RamW-1:UsedW];
  assign rd_bytes = ram_rdata[UsedW-1:0];

  assign req.ready = (op_i == OP_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_full  = out_vld_q && !rsp.ready;
  assign last      = (idx_q == SlotW'(SLOTS - 1));
  assign hit       = slot_vld_q[idx_q] && (rd_dev == id_q);
  assign fits      = need_q <= NEED_W'(rd_bytes);
  assign sum       = (NEED_W + 1)'(used_q) + (NEED_W + 1)'(need_q);
  assign overflow  = sum > ArenaV;

  assign flags_o = '{accept:    accept,
                     range_bad: (status_q == ST_RANGE),
                     hit:       hit,
                     nofit:     !free_found_q || overflow,
                     scan_last: last,
                     out_full:  out_full};

  // sizing arithmetic
  always_comb begin
    vec   = (cnt_q < 16'd2) ? 16'd2 : cnt_q;
    smear = vec - 16'd1;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    pow   = {1'b0, smear} + 17'd1;
    priority if (cfg_i.entry_bytes == '0) begin
      eb = CFG_W'(1);
    end else if (cfg_i.entry_bytes > CFG_W'(16)) begin
      eb = CFG_W'(16);
    end else begin
      eb = cfg_i.entry_bytes;
    end
    raw_full  = 22'(pow) * 22'(eb);
    quot      = prod_q[ProdW-1:RECIP_SHIFT];
    need_full = (QW + AlignW)'(quot) * (QW + AlignW)'(AlignV);
  end

  always_comb begin
    slot_vld_d    = slot_vld_q;
    used_d        = used_q;
    out_vld_d     = out_vld_q;
    id_d          = id_q;
    cnt_d         = cnt_q;
    raw_d         = raw_q;
    prod_d        = prod_q;
    need_d        = need_q;
    idx_d         = idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    status_d      = status_q;
    grant_off_d   = grant_off_q;
    grant_bytes_d = grant_bytes_q;
    out_d         = out_q;
    ram_we        = 1'b0;

    if (out_vld_q && rsp.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (op_i)
      OP_IDLE: begin
        idx_d = '0;
        if (accept) begin
          id_d          = req.data.device_id;
          cnt_d         = req.data.vector_count;
          free_found_d  = 1'b0;
          grant_off_d   = '0;
          grant_bytes_d = '0;
        end
      end
      OP_POW: begin
        raw_d    = raw_full[NEED_W-1:0];
        status_d = ((id_q >> cfg_i.device_id_bits) != 16'd0) ? ST_RANGE : ST_NEW;
      end
      OP_RECIP: begin
        prod_d = ProdW'(raw_q + AlignM1) * ProdW'(RecipV);
      end
      OP_ALIGN: begin
        need_d = need_full[NEED_W-1:0];
      end
      OP_SCAN: begin
        if (hit) begin
          status_d = fits ? ST_FITS : ST_SMALL;
        end else if (!slot_vld_q[idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (!last) begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      OP_ROOM: begin
        if (!free_found_q) begin
          status_d = ST_TABLE_FULL;
        end else if (overflow) begin
          status_d = ST_ARENA_FULL;
        end
      end
      OP_GRANT: begin
        ram_we                 = 1'b1;
        slot_vld_d[free_idx_q] = 1'b1;
        grant_off_d            = used_q;
        grant_bytes_d          = need_q[UsedW-1:0];
        used_d                 = sum[UsedW-1:0];
      end
      OP_RESULT: begin
        if (!out_full) begin
          out_vld_d        = 1'b1;
          out_d.status       = status_q;
          out_d.space_offset = off_w[11:0];
          out_d.space_bytes  = bytes_w[12:0];
        end
      end
    endcase
  end

  assign off_w   = (NEED_W + 1)'(grant_off_q);
  assign bytes_w = (NEED_W + 1)'(grant_bytes_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      used_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
      used_q     <= used_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q          <= id_d;
    cnt_q         <= cnt_d;
    raw_q         <= raw_d;
    prod_q        <= prod_d;
    need_q        <= need_d;
    idx_q         <= idx_d;
    free_found_q  <= free_found_d;
    free_idx_q    <= free_idx_d;
    status_q      <= status_d;
    grant_off_q   <= grant_off_d;
    grant_bytes_q <= grant_bytes_d;
    out_q         <= out_d;
  end

  assign rsp.valid = out_vld_q;
  assign rsp.data  = out_q;

`ifndef SYNTH
  a_arena_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(ArenaBytes))
    else $error("arena total beyond capacity");

  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_GRANT |-> free_found_q && !slot_vld_q[free_idx_q])
    else $error("grant into an occupied slot");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.status != ST_NEW |->
      rsp.data.space_offset == '0 && rsp.data.space_bytes == '0)
    else $error("space reported on a non-grant result");

  a_grant_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_GRANT |=> used_q == $past(sum[UsedW-1:0]))
    else $error("arena total not advanced by grant");
`endif

endmodule

// ----- src/interrupt_device_table_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the interrupt device table allocator: config registers, sequencer and datapath.
// Depends on idta_pkg, idta_chan_if, idta_seq and idta_dp.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        device_id[15:0], vector_count[15:0]
//   rsp_o    out  valid/ready        status[2:0], space_offset[11:0], space_bytes[12:0]
//   cfg      in   cfg_we_i (no wait) cfg_idx_i[0:0], cfg_wdata_i[4:0]
//
// From acceptance to a loaded result, a request runs the sizing steps, the slot scan through the
// single table RAM read port and the grant; an out-of-range ID or a hit skips ahead to the result.
// The next request can be taken in the cycle after the result is loaded, even while rsp_o stalls.
// Reset clears all slots and the arena total at once; no clearing pass.
module interrupt_device_table_allocator
  import idta_pkg::*;
#(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  idta_chan_if.sink            req_i,
  idta_chan_if.source          rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t      cfg_q, cfg_d;
  op_e       op;
  dp_flags_t flags;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEVICE_ID_BITS: cfg_d.device_id_bits = cfg_wdata_i;
        CFG_ENTRY_BYTES:    cfg_d.entry_bytes    = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{device_id_bits: ID_BITS_RST, entry_bytes: ENTRY_BYTES_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  idta_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .op_o   (op)
  );

  idta_dp #(.SLOTS(SLOTS), .ALIGN_BYTES(ALIGN_BYTES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .op_i   (op),
    .flags_o(flags),
    .req    (req_i),
    .rsp    (rsp_o)
  );

endmodule
